### rtl/sfii_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the step-function interval integral block.
// Depends on nothing; the cell, span unit and top level use it by scoped names.

package sfii_pkg;

    // Widths of the payload fields.
    localparam int TIME_W  = 32;
    localparam int VALUE_W = 24;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;
    localparam int ACC_W   = 64;
    localparam int LEN_W   = 32;
    localparam int PROD_W  = LEN_W + 1 + VALUE_W;

    // Times are carried one bit wider so that open span ends lie outside
    // every time that a breakpoint or a query bound can hold.
    typedef logic signed [TIME_W:0]    t_time_x;
    typedef logic signed [TIME_W-1:0]  t_time;
    typedef logic signed [VALUE_W-1:0] t_value;

    localparam t_time_x TIME_NEG_INF = {1'b1, {TIME_W{1'b0}}};
    localparam t_time_x TIME_POS_INF = {1'b0, {TIME_W{1'b1}}};

    // Configuration register indexes.
    typedef enum logic {
        CFG_FOOT  = 1'b0,
        CFG_COUNT = 1'b1
    } t_cfg_idx;

    // Item function codes.
    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // Query sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOOT,
        ST_ROT,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // One span term handed to the multiply-accumulate unit.
    typedef struct packed {
        logic    clr;
        logic    vld;
        t_time_x lo;
        t_time_x hi;
        t_time_x s;
        t_time_x f;
        t_value  val;
    } t_mac_req;

endpackage

### rtl/sfii_cell.sv
`timescale 1ns / 1ps
// One breakpoint cell of the rotating table: holds a time and a value.
// Depends on sfii_pkg.

module sfii_cell (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic                 i_wr_en,
    input  sfii_pkg::t_time      i_wr_time,
    input  sfii_pkg::t_value     i_wr_val,
    input  sfii_pkg::t_time      i_nb_time,
    input  sfii_pkg::t_value     i_nb_val,
    output sfii_pkg::t_time      o_time,
    output sfii_pkg::t_value     o_val
);

    sfii_pkg::t_time  r_time;
    sfii_pkg::t_value r_val;

    // During a query the cell takes its neighbor's entry; otherwise it is
    // loaded by a write word addressed to it.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_time <= i_nb_time;
            r_val  <= i_nb_val;
        end else if (i_wr_en) begin
            r_time <= i_wr_time;
            r_val  <= i_wr_val;
        end
    end

    assign o_time = r_time;
    assign o_val  = r_val;

endmodule

### rtl/sfii_mac.sv
`timescale 1ns / 1ps
// Three-stage span unit: clips a span to the query, multiplies its length
// by the value and accumulates modulo 2^64. Depends on sfii_pkg.

module sfii_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfii_pkg::t_mac_req            i_req,
    output logic [sfii_pkg::ACC_W-1:0]    o_acc
);

    logic                               r_v1;
    logic [sfii_pkg::LEN_W-1:0]         r_len;
    sfii_pkg::t_value                   r_mval;
    logic                               r_v2;
    logic signed [sfii_pkg::PROD_W-1:0] r_prod;
    logic [sfii_pkg::ACC_W-1:0]         r_acc;

    sfii_pkg::t_time_x                  w_a;
    sfii_pkg::t_time_x                  w_b;
    logic signed [sfii_pkg::TIME_W+1:0] w_diff;
    logic [sfii_pkg::LEN_W-1:0]         w_len;
    logic signed [sfii_pkg::PROD_W-1:0] w_prod;

    // Overlap of the span with [s, f); an empty overlap has length zero.
    always_comb begin
        w_a    = (i_req.lo > i_req.s) ? i_req.lo : i_req.s;
        w_b    = (i_req.hi < i_req.f) ? i_req.hi : i_req.f;
        w_diff = (sfii_pkg::TIME_W+2)'(w_b) - (sfii_pkg::TIME_W+2)'(w_a);
        w_len  = (w_b > w_a) ? w_diff[sfii_pkg::LEN_W-1:0] : '0;
        w_prod = $signed({1'b0, r_len}) * r_mval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= w_len;
        r_mval <= i_req.val;
        r_prod <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_req.clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(sfii_pkg::ACC_W-sfii_pkg::PROD_W){r_prod[sfii_pkg::PROD_W-1]}},
                              r_prod};
        end
    end

    assign o_acc = r_acc;

endmodule

### rtl/step_function_interval_integral.sv
`timescale 1ns / 1ps
// Top level of the step-function interval integral block.
// Depends on sfii_pkg, sfii_cell and sfii_mac.
//
//  Channel   | Handshake              | Payload
//  ----------+------------------------+---------------------------------------------
//  item in   | start, busy            | i_func, i_entry_index, i_entry_time,
//            |                        | i_entry_value, i_start_time, i_final_time
//  result    | o_done (strobe)        | o_integral
//  config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// A write word is written into its cell when taken and never raises busy.
// A query word holds busy through the states FOOT, ROT, DRAIN and DONE: the
// foot span, one rotation of the breakpoint table through the cell chain
// feeding the span unit, and the drain of the span unit's pipeline; o_done
// pulses in DONE, the last of them. Reset clears the sequencer, the
// configuration registers and the accumulator; the table itself is undefined
// until written. The receiver cannot stall, so the result strobe is shown for
// exactly one cycle; o_integral holds the result until the next query.

module step_function_interval_integral #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic [sfii_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic signed [sfii_pkg::TIME_W-1:0] i_entry_time,
    input  logic signed [sfii_pkg::VALUE_W-1:0] i_entry_value,
    input  logic signed [sfii_pkg::TIME_W-1:0] i_start_time,
    input  logic signed [sfii_pkg::TIME_W-1:0] i_final_time,
    output logic                               o_done,
    output logic signed [sfii_pkg::ACC_W-1:0]  o_integral,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [sfii_pkg::VALUE_W-1:0]       i_cfg_data
);

    // Rotation position and entry count widths.
    localparam int PW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (NW > sfii_pkg::COUNT_W) ? NW : sfii_pkg::COUNT_W;

    sfii_pkg::t_state            r_state;
    sfii_pkg::t_state            n_state;
    logic [PW-1:0]               r_pos;
    logic                        r_drn;
    sfii_pkg::t_value            r_foot;
    logic [sfii_pkg::COUNT_W-1:0] r_count;
    sfii_pkg::t_time_x           r_s;
    sfii_pkg::t_time_x           r_f;

    logic                        w_acc_q;
    logic                        w_acc_w;
    logic                        w_shift;
    logic                        w_pos_last;
    logic [CW-1:0]               w_cnt_ext;
    logic [NW-1:0]               w_n;
    logic [NW-1:0]               w_pos_ext;
    logic [NW-1:0]               w_pos_nxt;
    sfii_pkg::t_mac_req          w_req;
    logic [sfii_pkg::ACC_W-1:0]  w_acc;

    sfii_pkg::t_time             w_time [MAX_ENTRIES];
    sfii_pkg::t_value            w_val  [MAX_ENTRIES];

    // Word acceptance on the item channel.
    assign w_acc_q = start && !busy && (i_func == sfii_pkg::FUNC_QUERY);
    assign w_acc_w = start && !busy && (i_func == sfii_pkg::FUNC_WRITE);

    // Entries in use, limited to the table depth.
    always_comb begin
        w_cnt_ext = CW'(r_count);
        w_n       = (w_cnt_ext > CW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : w_cnt_ext[NW-1:0];
        w_pos_ext = NW'(r_pos);
        w_pos_nxt = w_pos_ext + NW'(1);
        w_pos_last = (r_pos == PW'(MAX_ENTRIES - 1));
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_foot  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            unique case (sfii_pkg::t_cfg_idx'(i_cfg_idx))
                sfii_pkg::CFG_FOOT:  r_foot  <= i_cfg_data;
                sfii_pkg::CFG_COUNT: r_count <= i_cfg_data[sfii_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Query bounds, held for the whole walk.
    always_ff @(posedge i_clk) begin
        if (w_acc_q) begin
            r_s <= sfii_pkg::t_time_x'(i_start_time);
            r_f <= sfii_pkg::t_time_x'(i_final_time);
        end
    end

    // Sequencer state register and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfii_pkg::ST_IDLE;
            r_pos   <= '0;
            r_drn   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= (r_state == sfii_pkg::ST_ROT) ? r_pos + PW'(1) : '0;
            r_drn   <= (r_state == sfii_pkg::ST_DRAIN) ? !r_drn : 1'b0;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfii_pkg::ST_IDLE:  if (w_acc_q) n_state = sfii_pkg::ST_FOOT;
            sfii_pkg::ST_FOOT:  n_state = sfii_pkg::ST_ROT;
            sfii_pkg::ST_ROT:   if (w_pos_last) n_state = sfii_pkg::ST_DRAIN;
            sfii_pkg::ST_DRAIN: if (r_drn) n_state = sfii_pkg::ST_DONE;
            sfii_pkg::ST_DONE:  n_state = sfii_pkg::ST_IDLE;
            default:            n_state = sfii_pkg::ST_IDLE;
        endcase
    end

    // Output logic: handshake, rotation and the span handed to the unit.
    always_comb begin
        busy    = 1'b1;
        o_done  = 1'b0;
        w_shift = 1'b0;
        w_req.clr = 1'b0;
        w_req.vld = 1'b0;
        w_req.s   = r_s;
        w_req.f   = r_f;
        w_req.lo  = sfii_pkg::TIME_NEG_INF;
        w_req.hi  = sfii_pkg::TIME_POS_INF;
        w_req.val = r_foot;
        unique case (r_state)
            sfii_pkg::ST_IDLE: begin
                busy      = 1'b0;
                w_req.clr = w_acc_q;
            end
            sfii_pkg::ST_FOOT: begin
                // The foot span ends at the first breakpoint, if there is one.
                w_req.vld = 1'b1;
                if (w_n != '0) begin
                    w_req.hi = sfii_pkg::t_time_x'(w_time[0]);
                end
            end
            sfii_pkg::ST_ROT: begin
                // The head cell holds entry r_pos, its neighbor the next one.
                // The last entry in use runs on without an upper end.
                w_shift   = 1'b1;
                w_req.vld = (w_pos_ext < w_n);
                w_req.lo  = sfii_pkg::t_time_x'(w_time[0]);
                w_req.val = w_val[0];
                if (w_pos_nxt != w_n) begin
                    w_req.hi = sfii_pkg::t_time_x'(w_time[1]);
                end
            end
            sfii_pkg::ST_DRAIN: ;
            sfii_pkg::ST_DONE: begin
                o_done = 1'b1;
            end
            default: ;
        endcase
    end

    // The breakpoint table: a ring of cells that rotates once per query,
    // so it is back in its home position when the query ends.
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        sfii_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_shift),
            .i_wr_en   (w_acc_w && (32'(i_entry_index) == 32'(k))),
            .i_wr_time (i_entry_time),
            .i_wr_val  (i_entry_value),
            .i_nb_time (w_time[(k + 1) % MAX_ENTRIES]),
            .i_nb_val  (w_val[(k + 1) % MAX_ENTRIES]),
            .o_time    (w_time[k]),
            .o_val     (w_val[k])
        );
    end

    sfii_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_acc   (w_acc)
    );

    assign o_integral = w_acc;

endmodule

### rtl/sfii_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the step-function interval integral block, bound to
// its top level. Depends on step_function_interval_integral.

module sfii_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_func,
    input logic o_done
);

    // A result word appears only while a query is in progress.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a query");

    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // An accepted query occupies the block.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func) |=> busy)
        else $error("query accepted without going busy");

    // A table write finishes in its own cycle.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_func) |=> !busy)
        else $error("table write held the block busy");

    // Every query ends with a result word.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("query ended without a result");

endmodule

bind step_function_interval_integral sfii_checker u_sfii_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_func  (i_func),
    .o_done  (o_done)
);
